// ----- src/lpfp_pkg.sv -----
// Package for the length-prefixed frame parser: transfer types, result kind codes,
// parse phase codes and the state record passed between the parser modules.
// No dependencies.
package lpfp_pkg;

  // Result kinds
  localparam logic [2:0] K_COMMAND = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_EMPTY   = 3'd2;
  localparam logic [2:0] K_VERERR  = 3'd3;
  localparam logic [2:0] K_TRUNC   = 3'd4;

  // Parse phases
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_COMMAND = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  localparam logic [7:0] ARG_INDEX_MAX = 8'hFF;
  localparam logic [7:0] VERSION_RST   = 8'd1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] arg_index;
    logic       arg_last;
    logic       frame_last;
  } out_item_t;

  // Fixed-width part of the parser state
  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] length_high;
    logic [7:0] arg_count;
  } parse_state_t;

endpackage

// ----- src/lpfp_step.sv -----
// Next-state and result logic of the frame parser for one byte.
// Depends on lpfp_pkg.
module lpfp_step import lpfp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic [7:0]             expected_version,
  input  in_item_t               item,
  input  parse_state_t           st,
  input  logic [LENGTH_BITS-1:0] bytes_left,
  output parse_state_t           st_nxt,
  output logic [LENGTH_BITS-1:0] bytes_left_nxt,
  output logic                   res_valid,
  output out_item_t              res
);

  localparam logic [16:0] MAXLEN = 17'((18'd1 << LENGTH_BITS) - 18'd1);

  logic [16:0]            len_full;
  logic [LENGTH_BITS-1:0] len_clip;
  logic [7:0]             idx_inc;
  logic                   end_b;
  logic                   last_byte;

  // Length assembly with saturation to the counter width
  assign len_full  = {1'b0, st.length_high, item.frame_byte};
  assign len_clip  = LENGTH_BITS'((len_full > MAXLEN) ? MAXLEN : len_full);
  assign idx_inc   = (st.arg_count == ARG_INDEX_MAX) ? st.arg_count : st.arg_count + 8'd1;
  assign end_b     = item.frame_end;
  assign last_byte = (bytes_left[LENGTH_BITS-1:1] == '0);

  // One step of the parse
  always_comb begin
    st_nxt         = st;
    bytes_left_nxt = bytes_left;
    res_valid      = 1'b0;
    res            = '0;
    unique case (st.phase)
      PH_COMMAND: begin
        st_nxt.arg_count = '0;
        st_nxt.phase     = end_b ? PH_VERSION : PH_LEN_HI;
        res_valid        = 1'b1;
        res.kind         = K_COMMAND;
        res.value        = item.frame_byte;
        res.frame_last   = end_b;
      end
      PH_LEN_HI: begin
        st_nxt.length_high = item.frame_byte;
        if (end_b) begin
          st_nxt.phase   = PH_VERSION;
          res_valid      = 1'b1;
          res.kind       = K_TRUNC;
          res.arg_index  = st.arg_count;
          res.frame_last = 1'b1;
        end else begin
          st_nxt.phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (len_clip == '0) begin
          st_nxt.arg_count = idx_inc;
          st_nxt.phase     = end_b ? PH_VERSION : PH_LEN_HI;
          res_valid        = 1'b1;
          res.kind         = K_EMPTY;
          res.arg_index    = st.arg_count;
          res.arg_last     = 1'b1;
          res.frame_last   = end_b;
        end else if (end_b) begin
          st_nxt.phase   = PH_VERSION;
          res_valid      = 1'b1;
          res.kind       = K_TRUNC;
          res.arg_index  = st.arg_count;
          res.frame_last = 1'b1;
        end else begin
          bytes_left_nxt = len_clip;
          st_nxt.phase   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid     = 1'b1;
        res.arg_index = st.arg_count;
        if (last_byte) begin
          bytes_left_nxt   = '0;
          st_nxt.arg_count = idx_inc;
          st_nxt.phase     = end_b ? PH_VERSION : PH_LEN_HI;
          res.kind         = K_PAYLOAD;
          res.value        = item.frame_byte;
          res.arg_last     = 1'b1;
          res.frame_last   = end_b;
        end else if (end_b) begin
          bytes_left_nxt = '0;
          st_nxt.phase   = PH_VERSION;
          res.kind       = K_TRUNC;
          res.frame_last = 1'b1;
        end else begin
          bytes_left_nxt = bytes_left - LENGTH_BITS'(1);
          res.kind       = K_PAYLOAD;
          res.value      = item.frame_byte;
        end
      end
      PH_DISCARD: begin
        if (end_b) begin
          st_nxt.phase = PH_VERSION;
        end
      end
      default: begin
        // Version byte; unused phase codes land here too
        st_nxt.arg_count = '0;
        bytes_left_nxt   = '0;
        if (item.frame_byte != expected_version) begin
          st_nxt.phase   = end_b ? PH_VERSION : PH_DISCARD;
          res_valid      = 1'b1;
          res.kind       = K_VERERR;
          res.frame_last = end_b;
        end else if (end_b) begin
          st_nxt.phase   = PH_VERSION;
          res_valid      = 1'b1;
          res.kind       = K_TRUNC;
          res.frame_last = 1'b1;
        end else begin
          st_nxt.phase = PH_COMMAND;
        end
      end
    endcase
  end

endmodule

// ----- src/length_prefixed_frame_parser.sv -----
// Top level of the length-prefixed frame parser: input register, parse step, result register.
// Depends on lpfp_pkg and lpfp_step.
//
// Usage:
//   in_valid/in_ready/in_data carry one frame byte per transfer, with frame_end set on
//   the frame's last byte. out_valid/out_ready/out_data carry zero or one result per
//   byte: command, payload byte, empty argument, version error or truncated frame.
//   cfg_wr_en/cfg_wr_data write the expected version byte; write only while idle.
// Timing:
//   A transferred byte waits in the input register and is parsed from there; its result,
//   if any, goes into the result register once that register is free. Bytes that give
//   no result (length bytes, discarded bytes, a good version byte) still pass through
//   the input register. Sustained rate is one byte per cycle while out_ready stays high;
//   the phase and length-counter update is a single compare and decrement per byte.
// Reset (synchronous, rst_n low): both stages empty, parser waits for a version byte,
//   expected version returns to 1.
// Stall: while out_ready is low and a result is held, the input register holds its
//   byte and in_ready drops once that register is also full; nothing is lost.
module length_prefixed_frame_parser import lpfp_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0]             expected_version_r;
  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  parse_state_t           st_r, st_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                   res_valid;
  out_item_t              res;
  logic                   out_valid_r;
  out_item_t              out_item_r;
  logic                   s1_adv;

  // Stage handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= VERSION_RST;
    end else if (cfg_wr_en) begin
      expected_version_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  lpfp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .expected_version(expected_version_r),
    .item            (s1_item_r),
    .st              (st_r),
    .bytes_left      (bytes_left_r),
    .st_nxt          (st_nxt),
    .bytes_left_nxt  (bytes_left_nxt),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Parser state, updated once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '{phase: PH_VERSION, length_high: 8'd0, arg_count: 8'd0};
      bytes_left_r <= '0;
    end else if (s1_adv) begin
      st_r         <= st_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

`ifndef SYNTHESIS
  // Counter is live exactly while inside a payload
  a_left_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_PAYLOAD) == (bytes_left_r != '0))
    else $error("bytes_left out of step with phase");

  // A result closing the frame sends the parser back to the version byte
  a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_valid && res.frame_last) |=> (st_r.phase == PH_VERSION))
    else $error("frame closed but parser not at version byte");

  // Command and version error results carry argument index zero
  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.kind == K_COMMAND || out_item_r.kind == K_VERERR))
      |-> (out_item_r.arg_index == 8'd0))
    else $error("header result with nonzero argument index");

  // An empty result register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ----- bench/tb_length_prefixed_frame_parser.sv -----
// Testbench for length_prefixed_frame_parser: feeds frames byte by byte with random gaps
// and output stalls, predicts every result and compares it field by field.
// Depends on lpfp_pkg and the parser RTL.
module tb_length_prefixed_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfp_pkg::*;

  localparam int LEN_BITS      = 16;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BYTES  = 900;
  localparam int PAUSE_EVERY   = 400;

  typedef logic [7:0] frame_t[$];

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  // Predictor state
  logic [2:0]  prs_phase;
  logic [7:0]  len_hi_q;
  logic [15:0] remaining;
  logic [7:0]  arg_idx;
  logic [7:0]  version_q;

  out_item_t   pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          free_flow;

  length_prefixed_frame_parser #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One parse step of the deframer; returns 1 when the byte yields a result
  function automatic bit parse_byte(input in_item_t it, output out_item_t res);
    logic [16:0] len;
    bit          hit;
    logic [7:0]  b;
    logic        fin;
    b   = it.frame_byte;
    fin = it.frame_end;
    res = '0;
    hit = 1'b1;
    case (prs_phase)
      PH_COMMAND: begin
        arg_idx        = '0;
        prs_phase      = fin ? PH_VERSION : PH_LEN_HI;
        res.kind       = K_COMMAND;
        res.value      = b;
        res.frame_last = fin;
      end
      PH_LEN_HI: begin
        len_hi_q = b;
        if (fin) begin
          prs_phase      = PH_VERSION;
          res.kind       = K_TRUNC;
          res.arg_index  = arg_idx;
          res.frame_last = 1'b1;
        end else begin
          prs_phase = PH_LEN_LO;
          hit       = 1'b0;
        end
      end
      PH_LEN_LO: begin
        len = {1'b0, len_hi_q, b};
        if (len > (1 << LEN_BITS) - 1) len = 17'((1 << LEN_BITS) - 1);
        if (len == 0) begin
          res.kind       = K_EMPTY;
          res.arg_index  = arg_idx;
          res.arg_last   = 1'b1;
          res.frame_last = fin;
          if (arg_idx != ARG_INDEX_MAX) arg_idx = arg_idx + 8'd1;
          prs_phase = fin ? PH_VERSION : PH_LEN_HI;
        end else if (fin) begin
          prs_phase      = PH_VERSION;
          res.kind       = K_TRUNC;
          res.arg_index  = arg_idx;
          res.frame_last = 1'b1;
        end else begin
          remaining = len[15:0];
          prs_phase = PH_PAYLOAD;
          hit       = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        res.arg_index = arg_idx;
        if (remaining <= 1) begin
          remaining      = '0;
          res.kind       = K_PAYLOAD;
          res.value      = b;
          res.arg_last   = 1'b1;
          res.frame_last = fin;
          if (arg_idx != ARG_INDEX_MAX) arg_idx = arg_idx + 8'd1;
          prs_phase = fin ? PH_VERSION : PH_LEN_HI;
        end else if (fin) begin
          remaining      = '0;
          prs_phase      = PH_VERSION;
          res.kind       = K_TRUNC;
          res.frame_last = 1'b1;
        end else begin
          remaining = remaining - 16'd1;
          res.kind  = K_PAYLOAD;
          res.value = b;
        end
      end
      PH_DISCARD: begin
        hit = 1'b0;
        if (fin) prs_phase = PH_VERSION;
      end
      default: begin
        arg_idx   = '0;
        remaining = '0;
        if (b != version_q) begin
          prs_phase      = fin ? PH_VERSION : PH_DISCARD;
          res.kind       = K_VERERR;
          res.frame_last = fin;
        end else if (fin) begin
          prs_phase      = PH_VERSION;
          res.kind       = K_TRUNC;
          res.frame_last = 1'b1;
        end else begin
          prs_phase = PH_COMMAND;
          hit       = 1'b0;
        end
      end
    endcase
    return hit;
  endfunction

  // Result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d value %0h", out_data.kind,
               out_data.value);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.value !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_data.value);
          mismatches++;
        end
        if (out_data.arg_index !== want.arg_index) begin
          $error("arg_index: expected %0d, got %0d", want.arg_index, out_data.arg_index);
          mismatches++;
        end
        if (out_data.arg_last !== want.arg_last) begin
          $error("arg_last: expected %0b, got %0b", want.arg_last, out_data.arg_last);
          mismatches++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, out_data.frame_last);
          mismatches++;
        end
      end
    end
  end

  // Output back-pressure: bursts of ready broken by random stalls
  initial begin
    int run;
    int stall;
    out_ready <= 1'b0;
    forever begin
      run = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Send one byte; valid stays high afterwards so back-to-back transfers need no toggle
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int        gap;
    in_item_t  it;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.frame_byte = b;
    it.frame_end  = fin;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (parse_byte(it, res)) pending_results.push_back(res);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Stop sending and let every outstanding result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    version_q = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; some cut short, some plain noise
  task automatic make_random_frame(output frame_t f);
    int nargs;
    int len;
    int r;
    f = {};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) f.push_back(8'($urandom_range(0, 255)));
    else f.push_back(version_q);
    f.push_back(8'($urandom_range(0, 255)));
    nargs = $urandom_range(0, 4);
    repeat (nargs) begin
      r = $urandom_range(0, 99);
      if (r < 20) len = 0;
      else if (r < 80) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 300);
      f.push_back(len[15:8]);
      f.push_back(len[7:0]);
      repeat (len) f.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 15) f = f[0:$urandom_range(0, f.size() - 2)];
  endtask

  // Directed frames under the reset version
  task automatic test_directed_frames();
    send_frame('{8'h01, 8'h00});                                 // command only
    send_frame('{8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF});
    send_frame('{8'h02, 8'h01, 8'h02});                          // bad version, rest dropped
    send_frame('{8'h00});                                        // bad version, one byte
    send_frame('{8'h01});                                        // ends on version
    send_frame('{8'h01, 8'h07, 8'h00});                          // ends in length high
    send_frame('{8'h01, 8'h07, 8'hFF, 8'hFF});                   // ends in length low
    send_frame('{8'h01, 8'h07, 8'h00, 8'h03, 8'h55, 8'hAA});     // ends inside payload
    send_frame('{8'h01, 8'h09, 8'h00, 8'h00});                   // ends on empty argument
  endtask

  // More than 255 arguments: the index must stick at its maximum
  task automatic test_arg_saturation();
    frame_t f;
    f = '{8'h01, 8'h3C};
    repeat (260) begin
      f.push_back(8'h00);
      f.push_back(8'h00);
    end
    f.push_back(8'h00);
    f.push_back(8'h01);
    f.push_back(8'h5A);
    send_frame(f);
  endtask

  // Extreme and random version settings, matching and mismatching frames
  task automatic test_version_settings();
    logic [7:0] vers[3];
    vers = '{8'h00, 8'hFF, 8'($urandom_range(2, 254))};
    foreach (vers[i]) begin
      write_version(vers[i]);
      send_frame('{vers[i], 8'h11, 8'h00, 8'h01, 8'h80});
      send_frame('{~vers[i], 8'h11, 8'h00, 8'h01, 8'h80});
      send_frame('{vers[i]});
    end
  endtask

  // Bulk random traffic, pausing now and then until everything has drained
  task automatic test_random_traffic();
    frame_t f;
    int     sent;
    int     next_pause;
    sent       = 0;
    next_pause = PAUSE_EVERY;
    while (sent < RANDOM_BYTES) begin
      make_random_frame(f);
      send_frame(f);
      sent += f.size();
      if (sent >= next_pause) begin
        wait_idle();
        next_pause += PAUSE_EVERY;
      end
    end
  endtask

  // A stretch with no gaps on either side
  task automatic test_full_rate();
    frame_t f;
    int     sent;
    wait_idle();
    write_version(8'h01);
    free_flow = 1'b1;
    sent = 0;
    while (sent < 150) begin
      make_random_frame(f);
      send_frame(f);
      sent += f.size();
    end
    free_flow = 1'b0;
  endtask

  // Sequence of tests
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    free_flow   = 1'b0;
    prs_phase   = PH_VERSION;
    len_hi_q    = '0;
    remaining   = '0;
    arg_idx     = '0;
    version_q   = VERSION_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_arg_saturation();
    test_version_settings();
    test_random_traffic();
    test_full_rate();
    wait_idle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
